### src/mpmu_pkg.sv
// ----------------------------------------------------------------------------
// Max-product message update: shared package
// Payload types, command codes, and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mpmu_pkg;

  localparam int MAX_STATES_DEF = 16;
  localparam int OUT_CAP        = 16;
  localparam int DIV_STEPS      = 48;

  localparam logic [1:0] CMD_LOAD_VEC = 2'd0;
  localparam logic [1:0] CMD_LOAD_PW  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  index_a;
    logic [3:0]  index_b;
    logic [31:0] value_a;
    logic [31:0] value_b;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  state_index;
    logic [16:0] message;
    logic        last;
    logic        all_zero;
  } out_item_t;

  typedef struct packed {
    logic       init;
    logic       q_rd;
    logic       div_q;
    logic       div_n;
    logic       q_wr;
    logic       m_rd;
    logic       m_mul;
    logic       m_cmp;
    logic       f_wr;
    logic       n_rd;
    logic       emit;
    logic       last;
    logic [3:0] x;
    logic [3:0] y;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

### src/mpmu_div.sv
// ----------------------------------------------------------------------------
// Max-product message update: serial divider
// Restoring divider, 48-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module mpmu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quotient_o
);
  import mpmu_pkg::*;

  logic [31:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic [31:0] dvs_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_q, quo_q[47]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DIV_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### src/mpmu_dp.sv
// ----------------------------------------------------------------------------
// Max-product message update: datapath
// Vector and matrix stores, quotient/fresh buffers, multiplier, max tracking.
// ----------------------------------------------------------------------------
module mpmu_dp #(
  parameter int MAX_STATES = mpmu_pkg::MAX_STATES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  mpmu_pkg::in_item_t  item_i,
  input  mpmu_pkg::dp_cmd_t   cmd_i,
  output mpmu_pkg::dp_stat_t  stat_o,
  output logic                result_valid_o,
  output mpmu_pkg::out_item_t result_o
);
  import mpmu_pkg::*;

  localparam int AW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int PD  = MAX_STATES * MAX_STATES;
  localparam int PAW = $clog2(PD);

  logic [31:0] belief_mem [MAX_STATES];
  logic [31:0] msg_mem    [MAX_STATES];
  logic [31:0] pw_mem     [PD];
  logic [31:0] quot_mem   [MAX_STATES];
  logic [31:0] fresh_mem  [MAX_STATES];

  logic [31:0] bel_rd_q, msg_rd_q, pw_rd_q, qt_rd_q, fr_rd_q;
  logic [63:0] prod_q;
  logic [31:0] best_q, peak_q;
  logic        res_vld_q;
  out_item_t   res_q;

  logic        acc, ia_ok, ib_ok, ld_vec, ld_pw;
  logic [PAW-1:0] pw_wr_addr, pw_rd_addr;
  logic [AW-1:0]  xa, ya;
  logic [47:0] div_dividend, div_quo;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [31:0] quot_sat, prod_sat;
  logic [16:0] msg_val;
  logic        zero;

  assign acc    = start_i && !busy_i;
  assign ia_ok  = 32'(item_i.index_a) < 32'(MAX_STATES);
  assign ib_ok  = 32'(item_i.index_b) < 32'(MAX_STATES);
  assign ld_vec = acc && (item_i.cmd == CMD_LOAD_VEC) && ia_ok;
  assign ld_pw  = acc && (item_i.cmd == CMD_LOAD_PW) && ia_ok && ib_ok;

  assign pw_wr_addr = PAW'(PAW'(item_i.index_b) * PAW'(MAX_STATES) + PAW'(item_i.index_a));
  assign pw_rd_addr = PAW'(PAW'(cmd_i.y) * PAW'(MAX_STATES) + PAW'(cmd_i.x));
  assign xa = AW'(cmd_i.x);
  assign ya = AW'(cmd_i.y);

  assign zero = (peak_q == 32'd0);

  assign div_dividend = cmd_i.div_q ? {bel_rd_q, 16'd0} : {fr_rd_q, 16'd0};
  assign div_divisor  = cmd_i.div_q ? ((msg_rd_q == 32'd0) ? 32'd1 : msg_rd_q)
                                    : (zero ? 32'd1 : peak_q);

  mpmu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_q || cmd_i.div_n),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign quot_sat = (div_quo[47:32] != 16'd0) ? 32'hFFFF_FFFF : div_quo[31:0];
  assign prod_sat = (prod_q[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod_q[47:16];
  assign msg_val  = zero ? 17'd0 : div_quo[16:0];

  always_ff @(posedge clk_i) begin
    if (ld_vec) belief_mem[AW'(item_i.index_a)] <= item_i.value_a;
    if (ld_vec) begin
      msg_mem[AW'(item_i.index_a)] <= item_i.value_b;
    end else if (cmd_i.emit) begin
      msg_mem[ya] <= 32'(msg_val);
    end
    if (ld_pw) pw_mem[pw_wr_addr] <= item_i.value_a;
    if (cmd_i.q_wr) quot_mem[xa] <= quot_sat;
    if (cmd_i.f_wr) fresh_mem[ya] <= best_q;

    if (cmd_i.q_rd) begin
      bel_rd_q <= belief_mem[xa];
      msg_rd_q <= msg_mem[xa];
    end
    if (cmd_i.m_rd) begin
      pw_rd_q <= pw_mem[pw_rd_addr];
      qt_rd_q <= quot_mem[xa];
    end
    if (cmd_i.n_rd) fr_rd_q <= fresh_mem[ya];
    if (cmd_i.m_mul) prod_q <= qt_rd_q * pw_rd_q;

    if (cmd_i.init || cmd_i.f_wr) begin
      best_q <= 32'd0;
    end else if (cmd_i.m_cmp && (prod_sat > best_q)) begin
      best_q <= prod_sat;
    end
    if (cmd_i.init) begin
      peak_q <= 32'd0;
    end else if (cmd_i.f_wr && (best_q > peak_q)) begin
      peak_q <= best_q;
    end

    if (cmd_i.emit) begin
      res_q.state_index <= cmd_i.y;
      res_q.message     <= msg_val;
      res_q.last        <= cmd_i.last;
      res_q.all_zero    <= zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.emit;
    end
  end

  assign stat_o.div_done = div_done;
  assign result_valid_o  = res_vld_q;
  assign result_o        = res_q;

endmodule

### src/mpmu_ctrl.sv
// ----------------------------------------------------------------------------
// Max-product message update: controller
// Sequences quotient, matrix max and normalize phases over the active states.
// ----------------------------------------------------------------------------
module mpmu_ctrl #(
  parameter int MAX_STATES = mpmu_pkg::MAX_STATES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         cmd_code_i,
  input  logic [4:0]         num_states_i,
  input  mpmu_pkg::dp_stat_t stat_i,
  output mpmu_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);
  import mpmu_pkg::*;

  localparam int NMAX = (MAX_STATES < OUT_CAP) ? MAX_STATES : OUT_CAP;

  typedef enum logic [3:0] {
    S_IDLE, S_QRD, S_QSTART, S_QDIV, S_QWR, S_MRD, S_MMUL, S_MCMP,
    S_FWR, S_NRD, S_NSTART, S_NDIV, S_EMIT
  } state_e;

  state_e     state_q;
  logic [3:0] x_q, y_q;
  logic [4:0] n_q, n_eff;
  logic       x_end, y_end;

  always_comb begin
    if (num_states_i < 5'd2) begin
      n_eff = 5'd2;
    end else if (32'(num_states_i) > NMAX) begin
      n_eff = 5'(NMAX);
    end else begin
      n_eff = num_states_i;
    end
  end

  assign x_end = ({1'b0, x_q} == n_q - 5'd1);
  assign y_end = ({1'b0, y_q} == n_q - 5'd1);

  always_comb begin
    cmd_o       = '0;
    cmd_o.x     = x_q;
    cmd_o.y     = y_q;
    cmd_o.init  = (state_q == S_IDLE);
    cmd_o.q_rd  = (state_q == S_QRD);
    cmd_o.div_q = (state_q == S_QSTART);
    cmd_o.q_wr  = (state_q == S_QWR);
    cmd_o.m_rd  = (state_q == S_MRD);
    cmd_o.m_mul = (state_q == S_MMUL);
    cmd_o.m_cmp = (state_q == S_MCMP);
    cmd_o.f_wr  = (state_q == S_FWR);
    cmd_o.n_rd  = (state_q == S_NRD);
    cmd_o.div_n = (state_q == S_NSTART);
    cmd_o.emit  = (state_q == S_EMIT);
    cmd_o.last  = y_end;
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      n_q     <= 5'd2;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i && (cmd_code_i == CMD_COMPUTE)) begin
            n_q     <= n_eff;
            x_q     <= '0;
            y_q     <= '0;
            state_q <= S_QRD;
          end
        end
        S_QRD:    state_q <= S_QSTART;
        S_QSTART: state_q <= S_QDIV;
        S_QDIV:   if (stat_i.div_done) state_q <= S_QWR;
        S_QWR: begin
          if (x_end) begin
            x_q     <= '0;
            state_q <= S_MRD;
          end else begin
            x_q     <= x_q + 4'd1;
            state_q <= S_QRD;
          end
        end
        S_MRD:  state_q <= S_MMUL;
        S_MMUL: state_q <= S_MCMP;
        S_MCMP: begin
          if (x_end) begin
            state_q <= S_FWR;
          end else begin
            x_q     <= x_q + 4'd1;
            state_q <= S_MRD;
          end
        end
        S_FWR: begin
          x_q <= '0;
          if (y_end) begin
            y_q     <= '0;
            state_q <= S_NRD;
          end else begin
            y_q     <= y_q + 4'd1;
            state_q <= S_MRD;
          end
        end
        S_NRD:    state_q <= S_NSTART;
        S_NSTART: state_q <= S_NDIV;
        S_NDIV:   if (stat_i.div_done) state_q <= S_EMIT;
        S_EMIT: begin
          if (y_end) begin
            y_q     <= '0;
            state_q <= S_IDLE;
          end else begin
            y_q     <= y_q + 4'd1;
            state_q <= S_NRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> ({1'b0, x_q} < n_q))
    else $error("x counter beyond active states");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> ({1'b0, y_q} < n_q))
    else $error("y counter beyond active states");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && y_end) |=> (state_q == S_IDLE))
    else $error("controller did not finish after last element");

  a_compute_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i && cmd_code_i == CMD_COMPUTE) |=> (state_q == S_QRD))
    else $error("compute transaction not started");

endmodule

### src/max_product_message_update_unit.sv
// ----------------------------------------------------------------------------
// Max-product message update unit
// A compute transaction for n states uses a 48-step serial divider per
// quotient and per normalized element, and a read/multiply/compare walk
// over the matrix. Results come one per strobe, n per compute; the receiver
// cannot stall. Reset clears control state and sets num_states to 2; stores
// stay undefined.
// ----------------------------------------------------------------------------
module max_product_message_update_unit #(
  parameter int MAX_STATES = mpmu_pkg::MAX_STATES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mpmu_pkg::in_item_t  item_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [4:0]          cfg_data_i,
  output logic                result_valid_o,
  output mpmu_pkg::out_item_t result_o
);
  import mpmu_pkg::*;

  logic [4:0] num_states_q;
  dp_cmd_t    dp_cmd;
  dp_stat_t   dp_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q <= 5'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_states_q <= cfg_data_i;
    end
  end

  mpmu_ctrl #(.MAX_STATES(MAX_STATES)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .cmd_code_i   (item_i.cmd),
    .num_states_i (num_states_q),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd),
    .busy_o       (busy)
  );

  mpmu_dp #(.MAX_STATES(MAX_STATES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item_i),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
